// ----- rtl/core/cca_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants, microcode table and calendar helpers for the calendar clock
package cca_pkg;

  // widths
  localparam int SECONDS_WIDTH = 32;
  localparam int ADD_WIDTH     = (SECONDS_WIDTH < 32) ? SECONDS_WIDTH : 32;
  localparam int YEAR_WIDTH    = 14;
  localparam int DIV_WIDTH     = (ADD_WIDTH + 1 > YEAR_WIDTH) ? ADD_WIDTH + 1 : YEAR_WIDTH;
  localparam int DAY_WIDTH     = (ADD_WIDTH - 15 > 10) ? ADD_WIDTH - 15 : 10;
  localparam int REM_WIDTH     = 9;
  localparam int PC_WIDTH      = 4;
  localparam int ADDR_WIDTH    = 5;
  localparam int DATA_WIDTH    = 32;

  // divider: the dividend is split into two digits, each digit step divides the
  // remainder-so-far above the digit by a reciprocal multiply
  localparam int DIGIT_WIDTH   = 17;
  localparam int NUM_WIDTH     = 2 * DIGIT_WIDTH;
  localparam int SMALL_WIDTH   = REM_WIDTH + DIGIT_WIDTH;
  localparam int RECIP_SHIFT   = SMALL_WIDTH + REM_WIDTH;
  localparam int RECIP_WIDTH   = 31;
  localparam int PROD_WIDTH    = SMALL_WIDTH + RECIP_WIDTH;

  // calendar limits
  localparam logic [13:0] YEAR_MAX     = 14'd9999;
  localparam logic [13:0] YEAR_MIN     = 14'd1;
  localparam logic [3:0]  MONTH_FIRST  = 4'd1;
  localparam logic [3:0]  MONTH_LAST   = 4'd12;
  localparam logic [4:0]  DAY_FIRST    = 5'd1;
  localparam logic [4:0]  DAY_LAST     = 5'd31;
  localparam logic [4:0]  HOUR_LAST    = 5'd23;
  localparam logic [5:0]  MINUTE_LAST  = 6'd59;
  localparam logic [5:0]  SECOND_LAST  = 6'd59;
  localparam logic [8:0]  YMOD_LAST    = 9'd399;
  localparam logic [8:0]  DAYS_YEAR    = 9'd365;
  localparam logic [8:0]  DAYS_LEAP    = 9'd366;
  localparam logic [4:0]  FEB_LEAP     = 5'd29;

  // divisors for the shared divider
  localparam logic [REM_WIDTH-1:0] DIVISOR_400 = 9'd400;
  localparam logic [REM_WIDTH-1:0] DIVISOR_60  = 9'd60;
  localparam logic [REM_WIDTH-1:0] DIVISOR_24  = 9'd24;

  // rounded-up reciprocals, exact for every partial value below 2**SMALL_WIDTH
  localparam logic [RECIP_WIDTH-1:0] RECIP_400 = RECIP_WIDTH'(
    ((64'd1 << RECIP_SHIFT) + 64'(DIVISOR_400) - 64'd1) / 64'(DIVISOR_400));
  localparam logic [RECIP_WIDTH-1:0] RECIP_60  = RECIP_WIDTH'(
    ((64'd1 << RECIP_SHIFT) + 64'(DIVISOR_60) - 64'd1) / 64'(DIVISOR_60));
  localparam logic [RECIP_WIDTH-1:0] RECIP_24  = RECIP_WIDTH'(
    ((64'd1 << RECIP_SHIFT) + 64'(DIVISOR_24) - 64'd1) / 64'(DIVISOR_24));

  // reset values of the start registers and the clock
  localparam logic [13:0] YEAR_RESET   = 14'd2000;
  localparam logic [3:0]  MONTH_RESET  = 4'd1;
  localparam logic [4:0]  DAY_RESET    = 5'd1;
  localparam logic [8:0]  YMOD_RESET   = 9'd0;

  // days per month, common year
  localparam logic [4:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // register map
  typedef enum logic [2:0] {
    REG_START_YEAR   = 3'd0,
    REG_START_MONTH  = 3'd1,
    REG_START_DAY    = 3'd2,
    REG_START_HOUR   = 3'd3,
    REG_START_MINUTE = 3'd4,
    REG_START_SECOND = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] seconds_to_add;
  } in_item_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        year_overflow;
  } out_item_t;

  typedef struct packed {
    logic [13:0] start_year;
    logic [3:0]  start_month;
    logic [4:0]  start_day;
    logic [4:0]  start_hour;
    logic [5:0]  start_minute;
    logic [5:0]  start_second;
  } start_cfg_t;

  // datapath operations, one per microcode step
  typedef enum logic [3:0] {
    OP_NOP,
    OP_WAIT,
    OP_YEAR_MOD,
    OP_DIV_400,
    OP_RELOAD,
    OP_ADD_SEC,
    OP_DIV_60,
    OP_SET_SEC,
    OP_SET_MIN,
    OP_DIV_24,
    OP_SET_HOUR,
    OP_WALK,
    OP_EMIT
  } op_t;

  // jump conditions: jump to target when true, else fall through
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_GOTO,
    COND_NOT_ACCEPT,
    COND_NOT_KIND,
    COND_DIV_MORE,
    COND_WALK_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t                 op;
    cond_t               cond;
    logic [PC_WIDTH-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic item_valid;
    logic kind;
    logic div_last;
    logic walk_more;
    logic out_busy;
  } seq_status_t;

  typedef struct packed {
    logic                 load;
    logic                 step;
    logic [REM_WIDTH-1:0] divisor;
  } div_ctrl_t;

  // step addresses
  localparam logic [PC_WIDTH-1:0] STEP_WAIT     = 4'd0;
  localparam logic [PC_WIDTH-1:0] STEP_YEAR_MOD = 4'd1;
  localparam logic [PC_WIDTH-1:0] STEP_DIV_400  = 4'd2;
  localparam logic [PC_WIDTH-1:0] STEP_RELOAD   = 4'd3;
  localparam logic [PC_WIDTH-1:0] STEP_ADD_SEC  = 4'd4;
  localparam logic [PC_WIDTH-1:0] STEP_DIV_SEC  = 4'd5;
  localparam logic [PC_WIDTH-1:0] STEP_SET_SEC  = 4'd6;
  localparam logic [PC_WIDTH-1:0] STEP_DIV_MIN  = 4'd7;
  localparam logic [PC_WIDTH-1:0] STEP_SET_MIN  = 4'd8;
  localparam logic [PC_WIDTH-1:0] STEP_DIV_HOUR = 4'd9;
  localparam logic [PC_WIDTH-1:0] STEP_SET_HOUR = 4'd10;
  localparam logic [PC_WIDTH-1:0] STEP_WALK     = 4'd11;
  localparam logic [PC_WIDTH-1:0] STEP_EMIT     = 4'd12;
  localparam logic [PC_WIDTH-1:0] STEP_RETURN   = 4'd13;

  // control store
  function automatic ucode_t ucode_rom(input logic [PC_WIDTH-1:0] pc);
    ucode_t w;
    case (pc)
      STEP_WAIT:     w = '{op: OP_WAIT,     cond: COND_NOT_ACCEPT, target: STEP_WAIT};
      STEP_YEAR_MOD: w = '{op: OP_YEAR_MOD, cond: COND_NOT_KIND,   target: STEP_ADD_SEC};
      STEP_DIV_400:  w = '{op: OP_DIV_400,  cond: COND_DIV_MORE,   target: STEP_DIV_400};
      STEP_RELOAD:   w = '{op: OP_RELOAD,   cond: COND_NEXT,       target: STEP_WAIT};
      STEP_ADD_SEC:  w = '{op: OP_ADD_SEC,  cond: COND_NEXT,       target: STEP_WAIT};
      STEP_DIV_SEC:  w = '{op: OP_DIV_60,   cond: COND_DIV_MORE,   target: STEP_DIV_SEC};
      STEP_SET_SEC:  w = '{op: OP_SET_SEC,  cond: COND_NEXT,       target: STEP_WAIT};
      STEP_DIV_MIN:  w = '{op: OP_DIV_60,   cond: COND_DIV_MORE,   target: STEP_DIV_MIN};
      STEP_SET_MIN:  w = '{op: OP_SET_MIN,  cond: COND_NEXT,       target: STEP_WAIT};
      STEP_DIV_HOUR: w = '{op: OP_DIV_24,   cond: COND_DIV_MORE,   target: STEP_DIV_HOUR};
      STEP_SET_HOUR: w = '{op: OP_SET_HOUR, cond: COND_NEXT,       target: STEP_WAIT};
      STEP_WALK:     w = '{op: OP_WALK,     cond: COND_WALK_MORE,  target: STEP_WALK};
      STEP_EMIT:     w = '{op: OP_EMIT,     cond: COND_OUT_BUSY,   target: STEP_EMIT};
      STEP_RETURN:   w = '{op: OP_NOP,      cond: COND_GOTO,       target: STEP_WAIT};
      default:       w = '{op: OP_NOP,      cond: COND_GOTO,       target: STEP_WAIT};
    endcase
    return w;
  endfunction

  // gregorian leap rule from the year modulo 400
  function automatic logic is_leap(input logic [8:0] ymod);
    return (ymod[1:0] == 2'd0) && (ymod != 9'd100) && (ymod != 9'd200) && (ymod != 9'd300);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    if (month < MONTH_FIRST || month > MONTH_LAST) begin
      len = DAY_LAST;
    end else if (month == 4'd2 && leap) begin
      len = FEB_LEAP;
    end else begin
      len = MONTH_DAYS[month - 4'd1];
    end
    return len;
  endfunction

  function automatic logic [13:0] clamp_year(input logic [13:0] y);
    logic [13:0] r;
    if (y < YEAR_MIN) begin
      r = YEAR_MIN;
    end else if (y > YEAR_MAX) begin
      r = YEAR_MAX;
    end else begin
      r = y;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/calendar_clock_add_seconds_top.sv -----
`timescale 1ns / 1ps
// top level of the gregorian calendar clock with a seconds adder
//
//   channel  direction  handshake                  payload
//   item     in         item_valid / item_ready    kind, seconds_to_add
//   result   out        result_valid / result_ready  date-time, year_overflow
//   config   in         apb psel / penable / pwrite  start date-time registers
//
// from one accepted transaction to the next the sequencer runs 8 single steps, 3 divides
// (seconds, minutes, hours) in the shared reciprocal divider and a walk that steps once per
// year or month carried by the day count plus one closing walk step; a reload adds a
// year mod 400 divide and a reload step.
// item_ready is high only in the wait step; a new item is taken while a result still waits.
// the emit step holds while the result register is full and not taken.
// rst is synchronous; the clock returns to 2000-01-01 00:00:00 with default start registers.
module calendar_clock_add_seconds_top import cca_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  in_item_t              item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output out_item_t             result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  output logic [DATA_WIDTH-1:0] prdata,
  output logic                  pready
);

  start_cfg_t  cfg;
  seq_status_t status;
  op_t         op;

  assign item_ready = (op == OP_WAIT);

  cca_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cca_sequencer u_sequencer (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  cca_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .item_valid   (item_valid),
    .item         (item),
    .cfg          (cfg),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result),
    .status       (status)
  );

  // a taken transaction moves the sequencer off the wait step
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("sequencer stayed in wait after a transaction");

  // every delivered date-time has its fields in range; the day is checked only from below
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.month >= MONTH_FIRST && result.month <= MONTH_LAST &&
                     result.day >= DAY_FIRST && result.hour <= HOUR_LAST &&
                     result.minute <= MINUTE_LAST && result.second <= SECOND_LAST &&
                     result.year >= YEAR_MIN && result.year <= YEAR_MAX)
    else $error("result date-time out of range");

  // an overflow result carries the saturated date
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.year_overflow |-> result.year == YEAR_MAX &&
                     result.month == MONTH_LAST && result.day == DAY_LAST)
    else $error("overflow result not saturated");

endmodule

// ----- rtl/core/cca_cfg_regs.sv -----
`timescale 1ns / 1ps
// apb register bank holding the reload start date-time
module cca_cfg_regs import cca_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  output logic [DATA_WIDTH-1:0] prdata,
  output logic                  pready,
  output start_cfg_t            cfg
);

  logic       wr_en;
  reg_index_t index;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign index  = reg_index_t'(paddr[4:2]);

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_year   <= YEAR_RESET;
      cfg.start_month  <= MONTH_RESET;
      cfg.start_day    <= DAY_RESET;
      cfg.start_hour   <= '0;
      cfg.start_minute <= '0;
      cfg.start_second <= '0;
    end else if (wr_en) begin
      case (index)
        REG_START_YEAR:   cfg.start_year   <= pwdata[13:0];
        REG_START_MONTH:  cfg.start_month  <= pwdata[3:0];
        REG_START_DAY:    cfg.start_day    <= pwdata[4:0];
        REG_START_HOUR:   cfg.start_hour   <= pwdata[4:0];
        REG_START_MINUTE: cfg.start_minute <= pwdata[5:0];
        REG_START_SECOND: cfg.start_second <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (index)
      REG_START_YEAR:   prdata = DATA_WIDTH'(cfg.start_year);
      REG_START_MONTH:  prdata = DATA_WIDTH'(cfg.start_month);
      REG_START_DAY:    prdata = DATA_WIDTH'(cfg.start_day);
      REG_START_HOUR:   prdata = DATA_WIDTH'(cfg.start_hour);
      REG_START_MINUTE: prdata = DATA_WIDTH'(cfg.start_minute);
      REG_START_SECOND: prdata = DATA_WIDTH'(cfg.start_second);
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/cca_sequencer.sv -----
`timescale 1ns / 1ps
// microcode step counter with conditional jumps over the control store
module cca_sequencer import cca_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  seq_status_t status,
  output op_t         op
);

  logic [PC_WIDTH-1:0] pc;
  logic [PC_WIDTH-1:0] pc_next;
  ucode_t              word;
  logic                take;

  // fetch and branch decision
  always_comb begin
    word = ucode_rom(pc);
    case (word.cond)
      COND_NEXT:       take = 1'b0;
      COND_GOTO:       take = 1'b1;
      COND_NOT_ACCEPT: take = !status.item_valid;
      COND_NOT_KIND:   take = !status.kind;
      COND_DIV_MORE:   take = !status.div_last;
      COND_WALK_MORE:  take = status.walk_more;
      COND_OUT_BUSY:   take = status.out_busy;
      default:         take = 1'b1;
    endcase
    pc_next = take ? word.target : pc + 1'b1;
    op      = word.op;
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ----- rtl/core/cca_divider.sv -----
`timescale 1ns / 1ps
// division by a small constant: two digits, a reciprocal multiply per digit
module cca_divider import cca_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  div_ctrl_t            ctrl,
  input  logic [DIV_WIDTH-1:0] load_value,
  output logic [DIV_WIDTH-1:0] quotient,
  output logic [REM_WIDTH-1:0] remainder,
  output logic                 last
);

  logic [NUM_WIDTH-1:0]   num_r;
  logic [NUM_WIDTH-1:0]   quo_r;
  logic [REM_WIDTH-1:0]   rem_r;
  logic [DIGIT_WIDTH-1:0] qd_r;
  logic [1:0]             cnt;
  logic [SMALL_WIDTH-1:0] part;
  logic [RECIP_WIDTH-1:0] recip;
  logic [PROD_WIDTH-1:0]  prod;
  logic [SMALL_WIDTH-1:0] back;
  logic [SMALL_WIDTH-1:0] rest;

  // reciprocal of the selected divisor
  always_comb begin
    case (ctrl.divisor)
      DIVISOR_400: recip = RECIP_400;
      DIVISOR_24:  recip = RECIP_24;
      default:     recip = RECIP_60;
    endcase
  end

  // partial value is the remainder so far above the next digit, always below divisor * 2**17
  always_comb begin
    part = {rem_r, num_r[NUM_WIDTH-1 -: DIGIT_WIDTH]};
    prod = PROD_WIDTH'(part) * PROD_WIDTH'(recip);
    back = SMALL_WIDTH'(qd_r) * SMALL_WIDTH'(ctrl.divisor);
    rest = part - back;
  end

  // step count: even steps estimate the digit, odd steps form the remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.load) begin
      cnt <= '0;
    end else if (ctrl.step) begin
      cnt <= cnt + 2'd1;
    end
  end

  // quotient digits shift in from the bottom as dividend digits shift out of the top
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      num_r <= NUM_WIDTH'(load_value);
      quo_r <= '0;
      rem_r <= '0;
    end else if (ctrl.step) begin
      if (!cnt[0]) begin
        qd_r <= prod[RECIP_SHIFT +: DIGIT_WIDTH];
      end else begin
        rem_r <= rest[REM_WIDTH-1:0];
        quo_r <= {quo_r[NUM_WIDTH-DIGIT_WIDTH-1:0], qd_r};
        num_r <= {num_r[NUM_WIDTH-DIGIT_WIDTH-1:0], {DIGIT_WIDTH{1'b0}}};
      end
    end
  end

  assign quotient  = quo_r[DIV_WIDTH-1:0];
  assign remainder = rem_r;
  assign last      = (cnt == 2'd3);

endmodule

// ----- rtl/core/cca_datapath.sv -----
`timescale 1ns / 1ps
// time and date registers, day-carry walk and result register driven by microcode ops
module cca_datapath import cca_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  op_t         op,
  input  logic        item_valid,
  input  in_item_t    item,
  input  start_cfg_t  cfg,
  input  logic        result_ready,
  output logic        result_valid,
  output out_item_t   result,
  output seq_status_t status
);

  logic                 kind_r;
  logic [ADD_WIDTH-1:0] add_r;
  logic [13:0]          year_r;
  logic [3:0]           month_r;
  logic [DAY_WIDTH-1:0] day_r;
  logic [4:0]           hour_r;
  logic [5:0]           minute_r;
  logic [5:0]           second_r;
  logic [8:0]           ymod_r;
  logic                 ovf_r;

  div_ctrl_t            div_ctrl;
  logic [DIV_WIDTH-1:0] div_load_value;
  logic [DIV_WIDTH-1:0] quotient;
  logic [REM_WIDTH-1:0] remainder;
  logic                 div_last;

  logic                 accept;
  logic                 out_busy;
  logic                 emit;

  // reload values
  logic [13:0]          ld_year;
  logic [3:0]           ld_month;
  logic [4:0]           ld_mlen;
  logic [4:0]           ld_day;
  logic [4:0]           ld_hour;
  logic [5:0]           ld_minute;
  logic [5:0]           ld_second;

  // walk terms
  logic                 leap;
  logic [4:0]           mlen;
  logic [8:0]           ylen;
  logic                 walk_more_raw;
  logic                 take_year;
  logic                 year_step;
  logic                 walk_ovf;

  assign accept   = (op == OP_WAIT) && item_valid;
  assign out_busy = result_valid && !result_ready;
  assign emit     = (op == OP_EMIT) && !out_busy;

  // saturate the start values into range
  always_comb begin
    ld_year   = clamp_year(cfg.start_year);
    ld_month  = (cfg.start_month < MONTH_FIRST) ? MONTH_FIRST :
                (cfg.start_month > MONTH_LAST) ? MONTH_LAST : cfg.start_month;
    ld_mlen   = month_len(ld_month, is_leap(remainder));
    ld_day    = (cfg.start_day < DAY_FIRST) ? DAY_FIRST :
                (cfg.start_day > ld_mlen) ? ld_mlen : cfg.start_day;
    ld_hour   = (cfg.start_hour > HOUR_LAST) ? HOUR_LAST : cfg.start_hour;
    ld_minute = (cfg.start_minute > MINUTE_LAST) ? MINUTE_LAST : cfg.start_minute;
    ld_second = (cfg.start_second > SECOND_LAST) ? SECOND_LAST : cfg.start_second;
  end

  // one step of the day carry: a whole year from january, else one month
  always_comb begin
    leap          = is_leap(ymod_r);
    mlen          = month_len(month_r, leap);
    ylen          = leap ? DAYS_LEAP : DAYS_YEAR;
    walk_more_raw = day_r > DAY_WIDTH'(mlen);
    take_year     = (month_r == MONTH_FIRST) && (day_r > DAY_WIDTH'(ylen));
    year_step     = take_year || (month_r == MONTH_LAST);
    walk_ovf      = walk_more_raw && year_step && (year_r == YEAR_MAX);
  end

  // divider control
  always_comb begin
    div_ctrl       = '{load: 1'b0, step: 1'b0, divisor: DIVISOR_60};
    div_load_value = '0;
    case (op)
      OP_YEAR_MOD: begin
        div_ctrl.load  = 1'b1;
        div_load_value = DIV_WIDTH'(ld_year);
      end
      OP_ADD_SEC: begin
        div_ctrl.load  = 1'b1;
        div_load_value = DIV_WIDTH'(add_r) + DIV_WIDTH'(second_r);
      end
      OP_SET_SEC: begin
        div_ctrl.load  = 1'b1;
        div_load_value = quotient + DIV_WIDTH'(minute_r);
      end
      OP_SET_MIN: begin
        div_ctrl.load  = 1'b1;
        div_load_value = quotient + DIV_WIDTH'(hour_r);
      end
      OP_DIV_400: div_ctrl = '{load: 1'b0, step: 1'b1, divisor: DIVISOR_400};
      OP_DIV_60:  div_ctrl = '{load: 1'b0, step: 1'b1, divisor: DIVISOR_60};
      OP_DIV_24:  div_ctrl = '{load: 1'b0, step: 1'b1, divisor: DIVISOR_24};
      default: ;
    endcase
  end

  cca_divider u_divider (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (div_ctrl),
    .load_value (div_load_value),
    .quotient   (quotient),
    .remainder  (remainder),
    .last       (div_last)
  );

  // latch the accepted transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= item.kind;
      add_r  <= item.seconds_to_add[ADD_WIDTH-1:0];
    end
  end

  // clock state
  always_ff @(posedge clk) begin
    if (rst) begin
      year_r   <= YEAR_RESET;
      month_r  <= MONTH_RESET;
      day_r    <= DAY_WIDTH'(DAY_RESET);
      hour_r   <= '0;
      minute_r <= '0;
      second_r <= '0;
      ymod_r   <= YMOD_RESET;
      ovf_r    <= 1'b0;
    end else begin
      case (op)
        OP_RELOAD: begin
          year_r   <= ld_year;
          month_r  <= ld_month;
          day_r    <= DAY_WIDTH'(ld_day);
          hour_r   <= ld_hour;
          minute_r <= ld_minute;
          second_r <= ld_second;
          ymod_r   <= remainder;
        end
        OP_ADD_SEC: ovf_r <= 1'b0;
        OP_SET_SEC: second_r <= remainder[5:0];
        OP_SET_MIN: minute_r <= remainder[5:0];
        OP_SET_HOUR: begin
          hour_r <= remainder[4:0];
          day_r  <= day_r + quotient[DAY_WIDTH-1:0];
        end
        OP_WALK: begin
          if (walk_ovf) begin
            // saturate at the last second of the last year
            year_r   <= YEAR_MAX;
            month_r  <= MONTH_LAST;
            day_r    <= DAY_WIDTH'(DAY_LAST);
            hour_r   <= HOUR_LAST;
            minute_r <= MINUTE_LAST;
            second_r <= SECOND_LAST;
            ovf_r    <= 1'b1;
          end else if (walk_more_raw) begin
            if (take_year) begin
              day_r <= day_r - DAY_WIDTH'(ylen);
            end else begin
              day_r   <= day_r - DAY_WIDTH'(mlen);
              month_r <= (month_r == MONTH_LAST) ? MONTH_FIRST : month_r + 4'd1;
            end
            if (year_step) begin
              year_r <= year_r + 14'd1;
              ymod_r <= (ymod_r == YMOD_LAST) ? 9'd0 : ymod_r + 9'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= '{year: year_r, month: month_r, day: day_r[4:0], hour: hour_r,
                  minute: minute_r, second: second_r, year_overflow: ovf_r};
    end
  end

  // status to the sequencer
  always_comb begin
    status.item_valid = item_valid;
    status.kind       = kind_r;
    status.div_last   = div_last;
    status.walk_more  = walk_more_raw && !walk_ovf;
    status.out_busy   = out_busy;
  end

endmodule
